FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the ring meter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, masked while rst is high.
`define RMSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define RMSG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rmsg_pkg.sv
// ---------------------------------------------------------------------------
// rmsg_pkg
// Types, register codes, the Q15 sine table and colour helpers of the
// ring meter segment generator.
// ---------------------------------------------------------------------------
package rmsg_pkg;

  localparam int ANG_W  = 10;
  localparam int IDX_W  = 9;
  localparam int TRIG_W = 17;
  localparam int PROD_W = 25;
  localparam int COORD_W = 10;
  localparam int QUARTER_DEG = 90;

  typedef enum logic [2:0] {
    REG_VALUE_MIN  = 3'd0,
    REG_VALUE_MAX  = 3'd1,
    REG_LEFT_X     = 3'd2,
    REG_TOP_Y      = 3'd3,
    REG_RADIUS     = 3'd4,
    REG_RING_WIDTH = 3'd5,
    REG_SCHEME     = 3'd6,
    REG_BACKGROUND = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    SCH_RED       = 4'd0,
    SCH_GREEN     = 4'd1,
    SCH_BLUE      = 4'd2,
    SCH_RAINBOW   = 4'd3,
    SCH_RAMP_UP   = 4'd4,
    SCH_RAMP_DOWN = 4'd5,
    SCH_BLACK     = 4'd6,
    SCH_PINK      = 4'd7
  } scheme_t;

  localparam logic [15:0] COL_RED   = 16'hF800;
  localparam logic [15:0] COL_GREEN = 16'h07E0;
  localparam logic [15:0] COL_BLUE  = 16'h001F;
  localparam logic [15:0] COL_BLACK = 16'h0000;
  localparam logic [15:0] COL_PINK  = 16'hF81F;

  // Static ring geometry and colouring, held by the register file.
  typedef struct packed {
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [6:0]  rin;
    logic [6:0]  rout;
    logic [3:0]  scheme;
    logic [15:0] background;
  } ring_cfg_t;

  // One segment handed from the sequencer to the datapath.
  typedef struct packed {
    logic                    valid;
    logic signed [ANG_W-1:0] angle;
    logic [IDX_W-1:0]        idx;
    logic                    fill;
    logic                    last;
  } seg_ctl_t;

  localparam logic [15:0] SINE_Q15 [91] = '{
    16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
    16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927,
    16'd8481, 16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743,
    16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847,
    16'd18324, 16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
    16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763, 16'd23170,
    16'd23571, 16'd23965, 16'd24351, 16'd24730, 16'd25102, 16'd25466,
    16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166, 16'd27482,
    16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197,
    16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651,
    16'd31795, 16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365,
    16'd32449, 16'd32524, 16'd32588, 16'd32643, 16'd32688, 16'd32723,
    16'd32748, 16'd32763, 16'd32768
  };

  // Sine in Q15 for an angle in -180..359 degrees.
  function automatic logic signed [TRIG_W-1:0] sin_q15(input logic signed [ANG_W-1:0] a);
    logic [8:0]  d;
    logic [15:0] t;
    logic        neg;
    d   = (a < 0) ? 9'(a + 10'sd360) : 9'(a);
    neg = 1'b0;
    if (d <= 9'd90) begin
      t = SINE_Q15[d[6:0]];
    end else if (d <= 9'd180) begin
      t = SINE_Q15[7'(9'd180 - d)];
    end else if (d <= 9'd270) begin
      t   = SINE_Q15[7'(d - 9'd180)];
      neg = 1'b1;
    end else begin
      t   = SINE_Q15[7'(9'd360 - d)];
      neg = 1'b1;
    end
    return neg ? -$signed({1'b0, t}) : $signed({1'b0, t});
  endfunction

  // RGB565 rainbow: blue, cyan, green, yellow, red across 0..127.
  function automatic logic [15:0] rainbow(input logic [6:0] idx);
    logic [4:0] m;
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    m = idx[4:0];
    r = 5'd0;
    g = 6'd0;
    b = 5'd0;
    unique case (idx[6:5])
      2'd0: begin
        b = 5'd31;
        g = {m, 1'b0};
      end
      2'd1: begin
        b = 5'd31 - m;
        g = 6'd63;
      end
      2'd2: begin
        g = 6'd63;
        r = m;
      end
      default: begin
        g = 6'd63 - {m, 1'b0};
        r = 5'd31;
      end
    endcase
    return {r, g, b};
  endfunction

endpackage

FILE: rtl/rmsg_seg_pipe.sv
// ---------------------------------------------------------------------------
// rmsg_seg_pipe
// Segment datapath: angle to trig lookup and colour, trig times radius,
// centre offset and clamp into the output word register.
// ---------------------------------------------------------------------------
module rmsg_seg_pipe #(
  parameter int SEG  = 5,
  parameter int HALF = 150
) (
  input  logic                clk,
  input  logic                rst,
  input  rmsg_pkg::ring_cfg_t cfg,
  input  rmsg_pkg::seg_ctl_t  ctl,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [9:0]          inner_start_x,
  output logic [9:0]          inner_start_y,
  output logic [9:0]          outer_start_x,
  output logic [9:0]          outer_start_y,
  output logic [9:0]          inner_end_x,
  output logic [9:0]          inner_end_y,
  output logic [9:0]          outer_end_x,
  output logic [9:0]          outer_end_y,
  output logic [15:0]         segment_colour,
  output logic                filled,
  output logic                last_segment
);

  localparam int NSEG = (2 * HALF + SEG - 1) / SEG;
  localparam int K_W  = $clog2(NSEG);

  // scheme colour of each segment for the three ramps
  logic [15:0] rb_full [NSEG];
  logic [15:0] rb_up   [NSEG];
  logic [15:0] rb_down [NSEG];

  for (genvar i = 0; i < NSEG; i++) begin : g_ramp
    localparam int T = i * SEG;
    assign rb_full[i] = rmsg_pkg::rainbow(7'(T * 127 / (2 * HALF)));
    assign rb_up[i]   = rmsg_pkg::rainbow(7'(T * 64 / (2 * HALF) + 63));
    assign rb_down[i] = rmsg_pkg::rainbow(7'(127 - T * 64 / (2 * HALF)));
  end

  assign adv = !out_valid || out_ready;

  // stage A: segment control
  logic                                 va;
  rmsg_pkg::seg_ctl_t                   sa;
  // stage B: trig values and colour
  logic                                 vb;
  logic signed [rmsg_pkg::TRIG_W-1:0]   tb [4];
  logic [15:0]                          colb;
  logic                                 fillb, lastb;
  // stage C: products
  logic                                 vc;
  logic signed [rmsg_pkg::PROD_W-1:0]   pc [8];
  logic [15:0]                          colc;
  logic                                 fillc, lastc;

  logic signed [rmsg_pkg::ANG_W-1:0]    ang_end;
  logic signed [rmsg_pkg::TRIG_W-1:0]   trig_next [4];
  logic [15:0]                          scheme_col;
  logic [K_W-1:0]                       ka;
  logic [9:0]                           pt [8];

  assign ang_end = sa.angle + rmsg_pkg::ANG_W'(SEG);
  assign ka      = sa.idx[K_W-1:0];

  always_comb begin
    trig_next[0] = rmsg_pkg::sin_q15(sa.angle);
    trig_next[1] = -rmsg_pkg::sin_q15(sa.angle + rmsg_pkg::ANG_W'(rmsg_pkg::QUARTER_DEG));
    trig_next[2] = rmsg_pkg::sin_q15(ang_end);
    trig_next[3] = -rmsg_pkg::sin_q15(ang_end + rmsg_pkg::ANG_W'(rmsg_pkg::QUARTER_DEG));
  end

  always_comb begin
    unique case (cfg.scheme)
      rmsg_pkg::SCH_RED:       scheme_col = rmsg_pkg::COL_RED;
      rmsg_pkg::SCH_GREEN:     scheme_col = rmsg_pkg::COL_GREEN;
      rmsg_pkg::SCH_BLUE:      scheme_col = rmsg_pkg::COL_BLUE;
      rmsg_pkg::SCH_RAINBOW:   scheme_col = rb_full[ka];
      rmsg_pkg::SCH_RAMP_UP:   scheme_col = rb_up[ka];
      rmsg_pkg::SCH_RAMP_DOWN: scheme_col = rb_down[ka];
      rmsg_pkg::SCH_BLACK:     scheme_col = rmsg_pkg::COL_BLACK;
      rmsg_pkg::SCH_PINK:      scheme_col = rmsg_pkg::COL_PINK;
      default:                 scheme_col = rmsg_pkg::COL_BLUE;
    endcase
  end

  // corner order: inner start, outer start, inner end, outer end (x then y)
  function automatic logic [9:0] place(input logic [9:0] c,
                                       input logic signed [rmsg_pkg::PROD_W-1:0] p);
    logic signed [26:0] s;
    s = $signed({2'b00, c, 15'd0}) + 27'(p);
    return (s < 0) ? 10'd0 : s[24:15];
  endfunction

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      pt[j] = place(j[0] ? cfg.cy : cfg.cx, pc[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va        <= ctl.valid;
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa    <= ctl;
      tb    <= trig_next;
      colb  <= sa.fill ? scheme_col : cfg.background;
      fillb <= sa.fill;
      lastb <= sa.last;
      for (int j = 0; j < 8; j++) begin
        pc[j] <= rmsg_pkg::PROD_W'(tb[{j[2], j[0]}] *
                 $signed({1'b0, (j[1] ? cfg.rout : cfg.rin)}));
      end
      colc  <= colb;
      fillc <= fillb;
      lastc <= lastb;
      inner_start_x  <= pt[0];
      inner_start_y  <= pt[1];
      outer_start_x  <= pt[2];
      outer_start_y  <= pt[3];
      inner_end_x    <= pt[4];
      inner_end_y    <= pt[5];
      outer_end_x    <= pt[6];
      outer_end_y    <= pt[7];
      segment_colour <= colc;
      filled         <= fillc;
      last_segment   <= lastc;
    end
  end

endmodule

FILE: rtl/ring_meter_segment_generator_core.sv
// First segment word: the gauge word passes the prep state, then each segment
// runs through stages A, B and C into the output register. One segment word per
// cycle while out_ready holds; the next gauge word waits until the sequencer
// has walked the ring. Output stalls freeze the four-stage segment pipeline
// as a whole. Reset: synchronous; clears control and loads register defaults.
// ---------------------------------------------------------------------------
// ring_meter_segment_generator_core
// Turns one gauge word into the segment words of a 300-degree ring meter:
// corner points, colour, fill and end-of-ring flag.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ring_meter_segment_generator_core #(
  parameter int SEGMENT_DEGREES    = 5,
  parameter int HALF_SWEEP_DEGREES = 150
) (
  input  logic               clk,
  input  logic               rst,
  // APB register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // gauge word in
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] gauge_value,
  // segment word out
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         inner_start_x,
  output logic [9:0]         inner_start_y,
  output logic [9:0]         outer_start_x,
  output logic [9:0]         outer_start_y,
  output logic [9:0]         inner_end_x,
  output logic [9:0]         inner_end_y,
  output logic [9:0]         outer_end_x,
  output logic [9:0]         outer_end_y,
  output logic [15:0]        segment_colour,
  output logic               filled,
  output logic               last_segment
);

  localparam int NSEG  = (2 * HALF_SWEEP_DEGREES + SEGMENT_DEGREES - 1) / SEGMENT_DEGREES;
  localparam int K_W   = $clog2(NSEG);
  // magnitudes of the scaled value and of the fill thresholds
  localparam int MAG_W = $clog2((2 * HALF_SWEEP_DEGREES + SEGMENT_DEGREES + 1) * 65536);

  // ---------------- register file ----------------
  logic signed [15:0] value_min, value_max;
  logic [8:0]         left_x, top_y;
  logic [6:0]         radius, ring_width;
  logic [3:0]         colour_scheme;
  logic [15:0]        background_colour;
  logic               wr_en;
  rmsg_pkg::reg_idx_t wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = rmsg_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      value_min         <= 16'sd0;
      value_max         <= 16'sd1020;
      left_x            <= 9'd0;
      top_y             <= 9'd0;
      radius            <= 7'd50;
      ring_width        <= 7'd10;
      colour_scheme     <= 4'd0;
      background_colour <= 16'd0;
    end else if (wr_en) begin
      unique case (wr_idx)
        rmsg_pkg::REG_VALUE_MIN:  value_min         <= pwdata[15:0];
        rmsg_pkg::REG_VALUE_MAX:  value_max         <= pwdata[15:0];
        rmsg_pkg::REG_LEFT_X:     left_x            <= pwdata[8:0];
        rmsg_pkg::REG_TOP_Y:      top_y             <= pwdata[8:0];
        rmsg_pkg::REG_RADIUS:     radius            <= pwdata[6:0];
        rmsg_pkg::REG_RING_WIDTH: ring_width        <= pwdata[6:0];
        rmsg_pkg::REG_SCHEME:     colour_scheme     <= pwdata[3:0];
        rmsg_pkg::REG_BACKGROUND: background_colour <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      rmsg_pkg::REG_VALUE_MIN:  prdata = {16'd0, value_min};
      rmsg_pkg::REG_VALUE_MAX:  prdata = {16'd0, value_max};
      rmsg_pkg::REG_LEFT_X:     prdata = {23'd0, left_x};
      rmsg_pkg::REG_TOP_Y:      prdata = {23'd0, top_y};
      rmsg_pkg::REG_RADIUS:     prdata = {25'd0, radius};
      rmsg_pkg::REG_RING_WIDTH: prdata = {25'd0, ring_width};
      rmsg_pkg::REG_SCHEME:     prdata = {28'd0, colour_scheme};
      rmsg_pkg::REG_BACKGROUND: prdata = {16'd0, background_colour};
      default:                  prdata = 32'd0;
    endcase
  end

  // ring geometry: centre and radii; inner radius saturates at zero
  rmsg_pkg::ring_cfg_t cfg;
  always_comb begin
    cfg.cx         = 10'(left_x) + 10'(radius);
    cfg.cy         = 10'(top_y) + 10'(radius);
    cfg.rin        = (radius >= ring_width) ? radius - ring_width : 7'd0;
    cfg.rout       = radius;
    cfg.scheme     = colour_scheme;
    cfg.background = background_colour;
  end

  // ---------------- segment sequencer ----------------
  // Fill test without a divider: with N = (g - vmin) * 2H and D = vmax - vmin,
  // segment k is filled when N and D agree in sign and |N| >= (k*S + 1) * |D|.
  // The threshold advances by S*|D| per segment.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_RUN  = 3'b100
  } seq_state_t;

  seq_state_t                    state, state_next;
  logic signed [16:0]            diff;
  logic signed [16:0]            span;
  logic [15:0]                   span_mag;
  logic [MAG_W-1:0]              num_mag, thr, thr_step;
  logic                          same_sign, have_v;
  logic [K_W-1:0]                seg_k;
  logic signed [rmsg_pkg::ANG_W-1:0] seg_ang;
  logic                          seg_last;
  logic                          issue;
  logic                          adv;
  rmsg_pkg::seg_ctl_t            ctl;

  assign span     = 17'(value_max) - 17'(value_min);
  assign span_mag = span[16] ? 16'(-span) : span[15:0];
  assign have_v   = (span != 17'sd0);
  assign in_ready = (state == ST_IDLE);
  assign seg_last = (seg_k == K_W'(NSEG - 1));
  assign issue    = (state == ST_RUN) && adv;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_PREP;
      ST_PREP: state_next = ST_RUN;
      ST_RUN:  if (issue && seg_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      diff <= 17'(gauge_value) - 17'(value_min);
    end
    if (state == ST_PREP) begin
      // hold the scaled value and the first threshold for this gauge word
      num_mag   <= MAG_W'((diff[16] ? 16'(-diff) : diff[15:0]) *
                   (2 * HALF_SWEEP_DEGREES));
      same_sign <= (diff[16] == span[16]);
      thr       <= MAG_W'(span_mag);
      thr_step  <= MAG_W'(span_mag * SEGMENT_DEGREES);
      seg_k     <= '0;
      seg_ang   <= rmsg_pkg::ANG_W'(-HALF_SWEEP_DEGREES);
    end else if (issue) begin
      // advance to the next segment
      thr     <= thr + thr_step;
      seg_k   <= seg_k + 1'b1;
      seg_ang <= seg_ang + rmsg_pkg::ANG_W'(SEGMENT_DEGREES);
    end
  end

  always_comb begin
    ctl.valid = issue;
    ctl.angle = seg_ang;
    ctl.idx   = rmsg_pkg::IDX_W'(seg_k);
    ctl.fill  = have_v && same_sign && (num_mag >= thr);
    ctl.last  = seg_last;
  end

  rmsg_seg_pipe #(
    .SEG  (SEGMENT_DEGREES),
    .HALF (HALF_SWEEP_DEGREES)
  ) u_pipe (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .ctl            (ctl),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .inner_start_x  (inner_start_x),
    .inner_start_y  (inner_start_y),
    .outer_start_x  (outer_start_x),
    .outer_start_y  (outer_start_y),
    .inner_end_x    (inner_end_x),
    .inner_end_y    (inner_end_y),
    .outer_end_x    (outer_end_x),
    .outer_end_y    (outer_end_y),
    .segment_colour (segment_colour),
    .filled         (filled),
    .last_segment   (last_segment)
  );

  // ---------------- checks ----------------
  `RMSG_ASSERT(a_accept_to_prep, (in_valid && in_ready) |=> (state == ST_PREP), "accept did not start prep")
  `RMSG_ASSERT(a_last_to_idle, (issue && seg_last) |=> in_ready, "sequencer not idle after final segment")
  `RMSG_ASSERT(a_no_fill_flat, (issue && !have_v) |-> !ctl.fill, "segment filled with empty value range")
  `RMSG_ASSERT(a_issue_first_angle, ($past(state == ST_PREP) && issue) |-> (seg_k == '0), "first segment index not zero")

endmodule

FILE: tb/tb_ring_meter_segment_generator_core.sv
// ---------------------------------------------------------------------------
// tb_ring_meter_segment_generator_core
// Drives gauge words into the ring meter core under several register
// settings and checks every segment word against a predicted ring.
// ---------------------------------------------------------------------------
module tb_ring_meter_segment_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG_DEG = 5;
  localparam int HALF_DEG = 150;
  localparam int NSEG = 60;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct {
    logic [9:0]  isx, isy, osx, osy, iex, iey, oex, oey;
    logic [15:0] colour;
    logic        fill;
    logic        last;
  } segment_t;

  // Ring scoreboard: predicts the segment words of each gauge word and
  // compares the words leaving the block against them in order.
  class ring_scoreboard;
    int          vmin, vmax;
    int          lx, ty, rad, wid, sch, bg;
    segment_t    pending[$];
    int          mismatches;

    function void set_reg(rmsg_pkg::reg_idx_t r, int v);
      case (r)
        rmsg_pkg::REG_VALUE_MIN:  vmin = $signed(16'(v));
        rmsg_pkg::REG_VALUE_MAX:  vmax = $signed(16'(v));
        rmsg_pkg::REG_LEFT_X:     lx = v & 'h1FF;
        rmsg_pkg::REG_TOP_Y:      ty = v & 'h1FF;
        rmsg_pkg::REG_RADIUS:     rad = v & 'h7F;
        rmsg_pkg::REG_RING_WIDTH: wid = v & 'h7F;
        rmsg_pkg::REG_SCHEME:     sch = v & 'hF;
        rmsg_pkg::REG_BACKGROUND: bg = v & 'hFFFF;
        default: ;
      endcase
    endfunction

    function int sine(int a);
      int d;
      d = a % 360;
      if (d < 0) d += 360;
      if (d <= 90) return int'(rmsg_pkg::SINE_Q15[d]);
      if (d <= 180) return int'(rmsg_pkg::SINE_Q15[180 - d]);
      if (d <= 270) return -int'(rmsg_pkg::SINE_Q15[d - 180]);
      return -int'(rmsg_pkg::SINE_Q15[360 - d]);
    endfunction

    function logic [9:0] corner(int c, int trig, int r);
      longint p;
      p = longint'(c) * 32768 + longint'(trig) * r;
      if (p < 0) p = 0;
      return 10'(p >>> 15);
    endfunction

    function logic [15:0] hue(longint idx);
      int m, r, g, b;
      if (idx < 0 || idx > 127) return rmsg_pkg::COL_BLACK;
      m = int'(idx) & 31;
      r = 0; g = 0; b = 0;
      case (int'(idx) >> 5)
        0: begin b = 31; g = 2 * m; end
        1: begin b = 31 - m; g = 63; end
        2: begin g = 63; r = m; end
        default: begin g = 63 - 2 * m; r = 31; end
      endcase
      return 16'((r << 11) + (g << 5) + b);
    endfunction

    function longint ramp(int a, longint lo, longint hi);
      return longint'(a + HALF_DEG) * (hi - lo) / (2 * HALF_DEG) + lo;
    endfunction

    function logic [15:0] scheme_colour(int a);
      case (sch)
        rmsg_pkg::SCH_RED:       return rmsg_pkg::COL_RED;
        rmsg_pkg::SCH_GREEN:     return rmsg_pkg::COL_GREEN;
        rmsg_pkg::SCH_BLUE:      return rmsg_pkg::COL_BLUE;
        rmsg_pkg::SCH_RAINBOW:   return hue(ramp(a, 0, 127));
        rmsg_pkg::SCH_RAMP_UP:   return hue(ramp(a, 63, 127));
        rmsg_pkg::SCH_RAMP_DOWN: return hue(ramp(a, 127, 63));
        rmsg_pkg::SCH_BLACK:     return rmsg_pkg::COL_BLACK;
        rmsg_pkg::SCH_PINK:      return rmsg_pkg::COL_PINK;
        default:                 return rmsg_pkg::COL_BLUE;
      endcase
    endfunction

    // Note an accepted gauge word: queue its whole ring.
    function void note_gauge(logic signed [15:0] g);
      bit       have_v;
      longint   v;
      int       cx, cy, rin, cs, sn, ce, se;
      segment_t s;
      have_v = (vmax != vmin);
      v = 0;
      cx = lx + rad;
      cy = ty + rad;
      rin = (rad >= wid) ? rad - wid : 0;
      if (have_v)
        v = (longint'(g) - vmin) * (2 * HALF_DEG) / (longint'(vmax) - vmin) - HALF_DEG;
      for (int a = -HALF_DEG; a < HALF_DEG; a += SEG_DEG) begin
        cs = sine(a);
        sn = -sine(a + 90);
        ce = sine(a + SEG_DEG);
        se = -sine(a + SEG_DEG + 90);
        s.fill = have_v && (longint'(a) < v);
        s.isx = corner(cx, cs, rin);
        s.isy = corner(cy, sn, rin);
        s.osx = corner(cx, cs, rad);
        s.osy = corner(cy, sn, rad);
        s.iex = corner(cx, ce, rin);
        s.iey = corner(cy, se, rin);
        s.oex = corner(cx, ce, rad);
        s.oey = corner(cy, se, rad);
        s.colour = s.fill ? scheme_colour(a) : 16'(bg);
        s.last = (a + SEG_DEG >= HALF_DEG);
        pending.push_back(s);
      end
    endfunction

    // Compare one segment word with the oldest prediction.
    function void check_segment(segment_t got);
      segment_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected segment word");
        return;
      end
      e = pending.pop_front();
      if (got.isx !== e.isx || got.isy !== e.isy || got.osx !== e.osx ||
          got.osy !== e.osy || got.iex !== e.iex || got.iey !== e.iey ||
          got.oex !== e.oex || got.oey !== e.oey || got.colour !== e.colour ||
          got.fill !== e.fill || got.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("segment mismatch: exp %p got %p", e, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic signed [15:0] gauge_value = '0;
  logic out_valid, out_ready = 0;
  logic [9:0] inner_start_x, inner_start_y, outer_start_x, outer_start_y;
  logic [9:0] inner_end_x, inner_end_y, outer_end_x, outer_end_y;
  logic [15:0] segment_colour;
  logic filled, last_segment;

  ring_scoreboard ring_sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  longint cycles = 0;

  ring_meter_segment_generator_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Hard stop for a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: drop ready at random or for a long hold-off stretch.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every segment word taken at this edge.
  always @(posedge clk) begin
    segment_t got;
    if (!rst && out_valid && out_ready) begin
      got.isx = inner_start_x; got.isy = inner_start_y;
      got.osx = outer_start_x; got.osy = outer_start_y;
      got.iex = inner_end_x;   got.iey = inner_end_y;
      got.oex = outer_end_x;   got.oey = outer_end_y;
      got.colour = segment_colour;
      got.fill = filled;
      got.last = last_segment;
      ring_sb.check_segment(got);
    end
  end

  // Write one register through the APB port: setup, then access.
  task automatic write_reg(rmsg_pkg::reg_idx_t r, int v);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 5'(4 * int'(r)); pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ring_sb.set_reg(r, v);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // Offer one gauge word; hold it until it is taken.
  task automatic send_gauge(logic signed [15:0] g);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1;
    gauge_value <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ring_sb.note_gauge(g);
    in_valid <= 0;
    @(posedge clk);
  endtask

  // Wait for the ring to drain, then let the pipe settle.
  task automatic drain();
    while (ring_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup_ring(int vmin, int vmax, int lx, int ty, int rad, int wid,
                            int sch, int bg);
    write_reg(rmsg_pkg::REG_VALUE_MIN, vmin);
    write_reg(rmsg_pkg::REG_VALUE_MAX, vmax);
    write_reg(rmsg_pkg::REG_LEFT_X, lx);
    write_reg(rmsg_pkg::REG_TOP_Y, ty);
    write_reg(rmsg_pkg::REG_RADIUS, rad);
    write_reg(rmsg_pkg::REG_RING_WIDTH, wid);
    write_reg(rmsg_pkg::REG_SCHEME, sch);
    write_reg(rmsg_pkg::REG_BACKGROUND, bg);
  endtask

  task automatic random_setup();
    int rad;
    rad = $urandom_range(127, 1);
    setup_ring($urandom_range(65535), $urandom_range(65535), $urandom_range(319),
               $urandom_range(319), rad, $urandom_range(127, 1), $urandom_range(15),
               $urandom_range(65535));
  endtask

  // Mostly gauge values inside the configured range, some anywhere.
  function automatic logic signed [15:0] pick_gauge();
    int lo, hi;
    lo = ring_sb.vmin < ring_sb.vmax ? ring_sb.vmin : ring_sb.vmax;
    hi = ring_sb.vmin < ring_sb.vmax ? ring_sb.vmax : ring_sb.vmin;
    if ($urandom_range(3) == 0) return 16'($urandom_range(65535));
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  initial begin
    ring_sb = new();
    ring_sb.vmin = 0; ring_sb.vmax = 1020; ring_sb.lx = 0; ring_sb.ty = 0;
    ring_sb.rad = 50; ring_sb.wid = 10; ring_sb.sch = 0; ring_sb.bg = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset settings, ends of the range and beyond.
    send_gauge(16'sd0);
    send_gauge(16'sd1020);
    send_gauge(16'sd510);
    send_gauge(-16'sd32768);
    send_gauge(16'sd32767);
    drain();
    // Every scheme, rainbow ramps across the range.
    for (int s = 0; s < 16; s++) begin
      write_reg(rmsg_pkg::REG_SCHEME, s);
      send_gauge(16'(s * 64 + 40));
      drain();
    end
    // Equal range leaves every segment in the background colour.
    setup_ring(100, 100, 319, 319, 127, 127, rmsg_pkg::SCH_RAINBOW, 16'hFFFF);
    send_gauge(16'sd100);
    drain();
    // Ring wider than its radius, inverted and full-width range.
    setup_ring(32767, -32768, 0, 0, 1, 127, rmsg_pkg::SCH_PINK, 16'h1234);
    send_gauge(16'sd0);
    send_gauge(-16'sd32768);
    drain();

    // Random phases: sender rarely idle/receiver mostly idle, reversed, then none.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 79 : 0;
      recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 11 : 0;
      for (int k = 0; k < 50; k++) begin
        if (k % 12 == 0) begin
          drain();
          random_setup();
        end
        if (ph == 2 && k == 20) hold_off = 400;
        send_gauge(pick_gauge());
      end
    end
    drain();

    if (ring_sb.mismatches == 0 && ring_sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
